FILE: rtl/core/hcds_pkg.sv
`timescale 1ns / 1ps

package hcds_pkg;

	localparam int COORD_W  = 12;
	localparam int SAMPLE_W = 16;
	localparam int SLOPE_W  = 29;
	localparam int CFG_W    = 13;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int PROD_W   = CFG_W + 1 + DIFF_W;

	localparam logic signed [PROD_W-1:0] SLOPE_MAX = PROD_W'((1 << (SLOPE_W - 1)) - 1);

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	// bit positions in the per-item result mask
	localparam int KIND_ABOVE = 0;
	localparam int KIND_LEFT  = 1;
	localparam int KIND_LAST  = 2;
	localparam int KIND_N     = 3;

	typedef logic [COORD_W-1:0]  coord_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		coord_t              col;
		coord_t              row;
		sample_t             cur;
		sample_t             p0;
		sample_t             p1;
		sample_t             up_left;
		sample_t             up;
		sample_t             old;
		sample_t             up_right;
		logic                c_ge1;
		logic                c_ge2;
		logic                r_ge1;
		logic                r_ge2;
		logic [KIND_N-1:0]   emit;
	} op_t;

	typedef struct packed {
		coord_t                      col;
		coord_t                      row;
		logic signed [SLOPE_W-1:0]   slope_h;
		logic signed [SLOPE_W-1:0]   slope_v;
		logic                        done;
	} res_t;

endpackage

FILE: rtl/core/hcds_fifo.sv
`timescale 1ns / 1ps

module hcds_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic [CW-1:0]    count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

FILE: rtl/core/hcds_front.sv
`timescale 1ns / 1ps

module hcds_front #(
	parameter int COLS = 4096,
	parameter int ROWS = 4096,
	localparam int AW = (COLS > 1) ? $clog2(COLS) : 1,
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic [AW-1:0]     last_col,
	input  logic [RW-1:0]     last_row,
	input  logic              in_push,
	input  hcds_pkg::sample_t height_sample,
	output logic              in_full,
	output logic              op_push,
	output hcds_pkg::op_t     op,
	input  logic              op_full
);

	import hcds_pkg::*;

	sample_t newer_mem [COLS];
	sample_t older_mem [COLS];

	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	sample_t       p0_q;
	sample_t       p1_q;
	sample_t       upl_q;

	logic          s1_v;
	logic [AW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	sample_t       cur_s1;
	sample_t       up_s1;
	sample_t       old_s1;
	sample_t       nxt_s1;
	logic          c_ge1_s1;
	logic          c_ge2_s1;
	logic          r_ge1_s1;
	logic          r_ge2_s1;
	logic          lastcol_s1;
	logic          lastrow_s1;

	logic              acc;
	logic              s1_adv;
	logic              wr_en;
	logic [AW-1:0]     rd_next;
	sample_t           up_right;
	logic [KIND_N-1:0] emit;

	assign acc     = in_push && !in_full;
	assign in_full = s1_v && !s1_adv;
	assign wr_en   = s1_v && s1_adv;
	assign rd_next = col_q + 1'b1;

	// line stores: write the leaving item, read the entering one, forward on a clash
	always_ff @(posedge clk) begin
		if (wr_en) begin
			newer_mem[col_s1] <= cur_s1;
			older_mem[col_s1] <= up_s1;
		end
		if (acc) begin
			up_s1  <= (wr_en && col_s1 == col_q)   ? cur_s1 : newer_mem[col_q];
			nxt_s1 <= (wr_en && col_s1 == rd_next) ? cur_s1 : newer_mem[rd_next];
			old_s1 <= (wr_en && col_s1 == col_q)   ? up_s1  : older_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1     <= col_q;
			row_s1     <= row_q;
			cur_s1     <= height_sample;
			c_ge1_s1   <= (col_q != '0);
			c_ge2_s1   <= (32'(col_q) >= 32'd2);
			r_ge1_s1   <= (row_q != '0);
			r_ge2_s1   <= (32'(row_q) >= 32'd2);
			lastcol_s1 <= (col_q == last_col);
			lastrow_s1 <= (row_q == last_row);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (acc) begin
			s1_v <= 1'b1;
		end else if (s1_adv) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q != last_col) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
				row_q <= (row_q != last_row) ? row_q + 1'b1 : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_q  <= '0;
			p1_q  <= '0;
			upl_q <= '0;
		end else if (restart) begin
			p0_q  <= '0;
			p1_q  <= '0;
			upl_q <= '0;
		end else if (wr_en) begin
			p0_q  <= cur_s1;
			p1_q  <= p0_q;
			upl_q <= up_s1;
		end
	end

	// classify: which results this item releases
	always_comb begin
		emit             = '0;
		emit[KIND_ABOVE] = r_ge1_s1;
		emit[KIND_LEFT]  = lastrow_s1 && c_ge1_s1;
		emit[KIND_LAST]  = lastrow_s1 && lastcol_s1;
	end

	assign up_right = lastcol_s1 ? up_s1 : nxt_s1;
	assign s1_adv   = (emit == '0) || !op_full;
	assign op_push  = s1_v && (emit != '0) && !op_full;

	always_comb begin
		op          = '0;
		op.col      = COORD_W'(col_s1);
		op.row      = COORD_W'(row_s1);
		op.cur      = cur_s1;
		op.p0       = p0_q;
		op.p1       = p1_q;
		op.up_left  = upl_q;
		op.up       = up_s1;
		op.old      = old_s1;
		op.up_right = up_right;
		op.c_ge1    = c_ge1_s1;
		op.c_ge2    = c_ge2_s1;
		op.r_ge1    = r_ge1_s1;
		op.r_ge2    = r_ge2_s1;
		op.emit     = emit;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= last_col) && (row_q <= last_row))
		else $error("position counter beyond frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && !s1_adv |=> s1_v && $stable(cur_s1) && $stable(col_s1))
		else $error("stalled item lost in front stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_full |-> s1_v)
		else $error("input stalled with no item in front stage");

endmodule

FILE: rtl/core/hcds_back.sv
`timescale 1ns / 1ps

module hcds_back #(
	parameter int OUT_DEPTH = 4,
	localparam int CW = $clog2(OUT_DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [hcds_pkg::CFG_W-1:0] wid,
	input  logic [hcds_pkg::CFG_W-1:0] hgt,
	input  logic                       op_empty,
	output logic                       op_pop,
	input  hcds_pkg::op_t              op_in,
	input  logic                       pop,
	output logic                       empty,
	output hcds_pkg::res_t             res
);

	import hcds_pkg::*;

	function automatic logic signed [SLOPE_W-1:0] sat(input logic signed [PROD_W-1:0] p);
		if (p > SLOPE_MAX) begin
			return SLOPE_W'(SLOPE_MAX);
		end else if (p < -SLOPE_MAX) begin
			return SLOPE_W'(-SLOPE_MAX);
		end else begin
			return SLOPE_W'(p);
		end
	endfunction

	op_t               op_q;
	logic [KIND_N-1:0] pend_q;

	logic                      v_s1;
	logic signed [DIFF_W-1:0]  dx_s1;
	logic signed [DIFF_W-1:0]  dy_s1;
	coord_t                    col_s1;
	coord_t                    row_s1;
	logic                      done_s1;

	logic                      v_s2;
	logic signed [PROD_W-1:0]  px_s2;
	logic signed [PROD_W-1:0]  py_s2;
	coord_t                    col_s2;
	coord_t                    row_s2;
	logic                      done_s2;

	logic [CW-1:0]     out_count;
	logic              out_full;
	logic              room;
	logic              issue;
	logic [KIND_N-1:0] sel;
	logic [KIND_N-1:0] pend_rest;
	res_t              res_in;
	logic [$bits(res_t)-1:0] out_data;

	sample_t                  left;
	sample_t                  right;
	sample_t                  above;
	sample_t                  below;
	coord_t                   col_c;
	coord_t                   row_c;
	logic                     done_c;
	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;

	assign room      = (32'(out_count) + 32'(v_s1) + 32'(v_s2)) < OUT_DEPTH;
	assign issue     = (pend_q != '0) && room;
	assign sel       = pend_q & (~pend_q + 1'b1);
	assign pend_rest = pend_q & ~sel;
	assign op_pop    = !op_empty && ((pend_q == '0) || (issue && pend_rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (op_pop) begin
			pend_q <= op_in.emit;
		end else if (issue) begin
			pend_q <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op_in;
		end
	end

	always_comb begin
		if (sel[KIND_LAST]) begin
			col_c  = op_q.col;
			row_c  = op_q.row;
			left   = op_q.c_ge1 ? op_q.p0 : op_q.cur;
			right  = op_q.cur;
			above  = op_q.r_ge1 ? op_q.up : op_q.cur;
			below  = op_q.cur;
			done_c = 1'b1;
		end else if (sel[KIND_LEFT]) begin
			col_c  = op_q.col - 1'b1;
			row_c  = op_q.row;
			left   = op_q.c_ge2 ? op_q.p1 : op_q.p0;
			right  = op_q.cur;
			above  = op_q.r_ge1 ? op_q.up_left : op_q.p0;
			below  = op_q.p0;
			done_c = 1'b0;
		end else begin
			col_c  = op_q.col;
			row_c  = op_q.row - 1'b1;
			left   = op_q.c_ge1 ? op_q.up_left : op_q.up;
			right  = op_q.up_right;
			above  = op_q.r_ge2 ? op_q.old : op_q.up;
			below  = op_q.cur;
			done_c = 1'b0;
		end
	end

	assign dx = DIFF_W'(right) - DIFF_W'(left);
	assign dy = DIFF_W'(below) - DIFF_W'(above);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= dx;
		dy_s1   <= dy;
		col_s1  <= col_c;
		row_s1  <= row_c;
		done_s1 <= done_c;
		px_s2   <= $signed({1'b0, wid}) * dx_s1;
		py_s2   <= $signed({1'b0, hgt}) * dy_s1;
		col_s2  <= col_s1;
		row_s2  <= row_s1;
		done_s2 <= done_s1;
	end

	always_comb begin
		res_in         = '0;
		res_in.col     = col_s2;
		res_in.row     = row_s2;
		res_in.slope_h = sat(px_s2);
		res_in.slope_v = sat(py_s2);
		res_in.done    = done_s2;
	end

	hcds_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s2),
		.wdata  (res_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_data),
		.empty  (empty),
		.count  (out_count)
	);

	assign res = out_data;

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !out_full)
		else $error("result pushed into full output queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> $onehot(sel) && ((sel & pend_q) == sel))
		else $error("bad result selection");

	assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> (op_in.emit != '0))
		else $error("item taken with no result to release");

endmodule

FILE: rtl/core/heightmap_central_difference_slope.sv
`timescale 1ns / 1ps

// channel   | handshake                       | payload
// ----------+---------------------------------+----------------------------------------------
// input     | push, full   (push & !full)     | height_sample
// result    | empty, pop   (pop & !empty)     | pixel_col, pixel_row, slope_horizontal,
//           |                                 | slope_vertical, frame_done
// config    | cfg_we                          | cfg_index, cfg_data
//
// One item per cycle while each item yields at most one result and the result queue has
// room; on the last row an item yields up to three results, so there the output stage
// issues them one after another and holds off the next item until its last is issued.
// Reset clears counters, pixel window and queues; the line stores are not cleared.
// full rises only when the stage after the line stores cannot hand off its item.

module heightmap_central_difference_slope #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [hcds_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                push,
	input  logic [hcds_pkg::SAMPLE_W-1:0]       height_sample,
	output logic                                full,
	input  logic                                pop,
	output logic                                empty,
	output logic [hcds_pkg::COORD_W-1:0]        pixel_col,
	output logic [hcds_pkg::COORD_W-1:0]        pixel_row,
	output logic signed [hcds_pkg::SLOPE_W-1:0] slope_horizontal,
	output logic signed [hcds_pkg::SLOPE_W-1:0] slope_vertical,
	output logic                                frame_done
);

	import hcds_pkg::*;

	localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int MID_DEPTH = 2;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int limit);
		if (v == '0) begin
			return CFG_W'(1);
		end else if (32'(v) > limit) begin
			return CFG_W'(limit);
		end else begin
			return v;
		end
	endfunction

	localparam logic [CFG_W-1:0] WID_RST = clamp_dim(CFG_W'(4096), MAX_WIDTH);
	localparam logic [CFG_W-1:0] HGT_RST = clamp_dim(CFG_W'(4096), MAX_HEIGHT);

	logic [CFG_W-1:0] wid_q;
	logic [CFG_W-1:0] hgt_q;
	logic [AW-1:0]    last_col;
	logic [RW-1:0]    last_row;

	logic op_push;
	logic op_full;
	logic op_pop;
	logic op_empty;
	op_t  op_f;
	op_t  op_b;
	res_t res;
	logic [$clog2(MID_DEPTH + 1)-1:0] mid_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q <= WID_RST;
			hgt_q <= HGT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  wid_q <= clamp_dim(cfg_data, MAX_WIDTH);
				REG_HEIGHT: hgt_q <= clamp_dim(cfg_data, MAX_HEIGHT);
				default: ;
			endcase
		end
	end

	assign last_col = AW'(wid_q - 1'b1);
	assign last_row = RW'(hgt_q - 1'b1);

	hcds_front #(
		.COLS (MAX_WIDTH),
		.ROWS (MAX_HEIGHT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (cfg_we),
		.last_col      (last_col),
		.last_row      (last_row),
		.in_push       (push),
		.height_sample (height_sample),
		.in_full       (full),
		.op_push       (op_push),
		.op            (op_f),
		.op_full       (op_full)
	);

	hcds_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (MID_DEPTH)
	) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_f),
		.full   (op_full),
		.pop    (op_pop),
		.rdata  (op_b),
		.empty  (op_empty),
		.count  (mid_count)
	);

	hcds_back #(
		.OUT_DEPTH (4)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wid      (wid_q),
		.hgt      (hgt_q),
		.op_empty (op_empty),
		.op_pop   (op_pop),
		.op_in    (op_b),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign pixel_col        = res.col;
	assign pixel_row        = res.row;
	assign slope_horizontal = res.slope_h;
	assign slope_vertical   = res.slope_v;
	assign frame_done       = res.done;

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(mid_count) <= MID_DEPTH)
		else $error("middle queue over depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		op_push |-> !op_full)
		else $error("item pushed into full middle queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> !op_empty)
		else $error("item popped from empty middle queue");

endmodule

FILE: tb/slope_checker.sv
`timescale 1ns / 1ps

module slope_checker #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [hcds_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                push,
	input  logic [hcds_pkg::SAMPLE_W-1:0]       height_sample,
	input  logic                                full,
	input  logic                                pop,
	input  logic                                empty,
	input  logic [hcds_pkg::COORD_W-1:0]        pixel_col,
	input  logic [hcds_pkg::COORD_W-1:0]        pixel_row,
	input  logic signed [hcds_pkg::SLOPE_W-1:0] slope_horizontal,
	input  logic signed [hcds_pkg::SLOPE_W-1:0] slope_vertical,
	input  logic                                frame_done,
	output int                                  error_count,
	output int                                  pending
);

	import hcds_pkg::*;

	sample_t          row_above [MAX_WIDTH];
	sample_t          row_two_above [MAX_WIDTH];
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	int unsigned      next_col;
	int unsigned      next_row;
	sample_t          left1;
	sample_t          left2;
	sample_t          above_left;
	res_t             slopes_due [$];

	initial begin
		foreach (row_above[i]) begin
			row_above[i]     = '0;
			row_two_above[i] = '0;
		end
	end

	function automatic int unsigned usable_size(logic [CFG_W-1:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic signed [SLOPE_W-1:0] scaled_step(int unsigned factor, sample_t hi,
		sample_t lo);
		longint prod;
		prod = longint'(factor) * (longint'(hi) - longint'(lo));
		if (prod > SLOPE_MAX)
			prod = SLOPE_MAX;
		if (prod < -SLOPE_MAX)
			prod = -SLOPE_MAX;
		return prod[SLOPE_W-1:0];
	endfunction

	task automatic restart_frame();
		next_col   = 0;
		next_row   = 0;
		left1      = '0;
		left2      = '0;
		above_left = '0;
	endtask

	task automatic queue_slope(int unsigned col, int unsigned row, int unsigned w, int unsigned h,
		sample_t left, sample_t right, sample_t above, sample_t below, logic done);
		res_t rec;
		rec.col     = coord_t'(col);
		rec.row     = coord_t'(row);
		rec.slope_h = scaled_step(w, right, left);
		rec.slope_v = scaled_step(h, below, above);
		rec.done    = done;
		slopes_due.push_back(rec);
	endtask

	task automatic take_sample(sample_t cur);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		sample_t     up;
		sample_t     old;
		sample_t     up_right;
		sample_t     p0;
		sample_t     p1;
		sample_t     up_left;
		w        = usable_size(width_reg, MAX_WIDTH);
		h        = usable_size(height_reg, MAX_HEIGHT);
		c        = (next_col >= w) ? w - 1 : next_col;
		r        = (next_row >= h) ? h - 1 : next_row;
		p0       = left1;
		p1       = left2;
		up_left  = above_left;
		up       = row_above[c];
		old      = row_two_above[c];
		up_right = (c + 1 < w) ? row_above[c + 1] : up;

		if (r >= 1)
			queue_slope(c, r - 1, w, h, (c >= 1) ? up_left : up, up_right,
				(r >= 2) ? old : up, cur, 1'b0);
		if (r == h - 1) begin
			if (c >= 1)
				queue_slope(c - 1, r, w, h, (c >= 2) ? p1 : p0, cur,
					(r >= 1) ? up_left : p0, p0, 1'b0);
			if (c == w - 1)
				queue_slope(c, r, w, h, (c >= 1) ? p0 : cur, cur,
					(r >= 1) ? up : cur, cur, 1'b1);
		end

		row_two_above[c] = up;
		row_above[c]     = cur;
		above_left       = up;
		left2            = p0;
		left1            = cur;

		if (c + 1 < w) begin
			next_col = c + 1;
			next_row = r;
		end else if (r + 1 < h) begin
			next_col = 0;
			next_row = r + 1;
		end else begin
			next_col = 0;
			next_row = 0;
		end
	endtask

	task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			slopes_due.delete();
			width_reg  = 13'd4096;
			height_reg = 13'd4096;
			restart_frame();
		end else begin
			if (pop && !empty) begin
				if (slopes_due.size() == 0) begin
					error_count++;
					$display("%0t: result col %0d row %0d arrived with none expected",
						$time, pixel_col, pixel_row);
				end else begin
					want = slopes_due.pop_front();
					compare_field("pixel_col", want.col, pixel_col);
					compare_field("pixel_row", want.row, pixel_row);
					compare_field("slope_horizontal", want.slope_h, slope_horizontal);
					compare_field("slope_vertical", want.slope_v, slope_vertical);
					compare_field("frame_done", want.done, frame_done);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
				restart_frame();
			end
			if (push && !full)
				take_sample(height_sample);
		end
		pending = slopes_due.size();
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	import hcds_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_ITEMS  = 140;
	localparam int IDLE_PCT      = 21;

	localparam sample_t CORNER_SET [9] = '{
		16'h0000, 16'hFFFF, 16'h5555,
		16'hAAAA, 16'h0000, 16'hFFFF,
		16'h1234, 16'hFFFF, 16'h0000
	};

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      cfg_we        = 1'b0;
	logic                      cfg_index     = 1'b0;
	logic [CFG_W-1:0]          cfg_data      = '0;
	logic                      push          = 1'b0;
	sample_t                   height_sample = '0;
	logic                      full;
	logic                      pop           = 1'b0;
	logic                      empty;
	coord_t                    pixel_col;
	coord_t                    pixel_row;
	logic signed [SLOPE_W-1:0] slope_horizontal;
	logic signed [SLOPE_W-1:0] slope_vertical;
	logic                      frame_done;
	int                        error_count;
	int                        pending;
	bit                        steady      = 1'b0;
	int                        hold_asked  = 0;
	int                        hold_served = 0;
	int                        hold_left   = 0;
	int unsigned               cycle_count = 0;

	heightmap_central_difference_slope DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.push            (push),
		.height_sample   (height_sample),
		.full            (full),
		.pop             (pop),
		.empty           (empty),
		.pixel_col       (pixel_col),
		.pixel_row       (pixel_row),
		.slope_horizontal(slope_horizontal),
		.slope_vertical  (slope_vertical),
		.frame_done      (frame_done)
	);

	slope_checker slope_watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.push            (push),
		.height_sample   (height_sample),
		.full            (full),
		.pop             (pop),
		.empty           (empty),
		.pixel_col       (pixel_col),
		.pixel_row       (pixel_row),
		.slope_horizontal(slope_horizontal),
		.slope_vertical  (slope_vertical),
		.frame_done      (frame_done),
		.error_count     (error_count),
		.pending         (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// hold results back for a long stretch on request, otherwise pop at random, or always while steady
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic sample_t pick_height();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic offer_sample(sample_t v);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push          <= 1'b1;
		height_sample <= v;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// ramp puts full-scale steps on the first items of the frame
	task automatic send_frame(int n, bit ramp);
		for (int i = 0; i < n; i++) begin
			if (ramp && i < 8)
				offer_sample((i % 4 < 2) ? 16'h0000 : 16'hFFFF);
			else
				offer_sample(pick_height());
		end
		push <= 1'b0;
	endtask

	task automatic set_frame_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int random_items;
		int w;
		int h;
		int n;
		random_items = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_frame_size(13'd3, 13'd3);
		foreach (CORNER_SET[i])
			offer_sample(CORNER_SET[i]);
		push <= 1'b0;
		drain();

		// zero size acts as one pixel
		set_frame_size(13'd0, 13'd0);
		offer_sample(16'hFFFF);
		offer_sample(16'h0000);
		push <= 1'b0;
		drain();

		set_frame_size(13'd2, 13'd1);
		offer_sample(16'h0000);
		offer_sample(16'hFFFF);
		push <= 1'b0;
		drain();

		// stop mid-frame; the next write restarts it
		set_frame_size(13'd4, 13'd3);
		send_frame(6, 1'b0);
		drain();

		set_frame_size(13'd4096, 13'd1);
		send_frame(50, 1'b1);
		drain();

		// oversize acts as the maximum; stop mid-frame
		hold_asked++;
		set_frame_size(13'd8191, 13'd1);
		send_frame(40, 1'b1);
		drain();

		steady = 1'b1;
		set_frame_size(13'd1, 13'd8191);
		send_frame(80, 1'b1);
		drain();
		steady = 1'b0;

		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				w = $urandom_range(7, 40);
			else
				w = $urandom_range(1, 6);
			h = $urandom_range(1, 5);
			n = w * h;
			if (n > 1 && $urandom_range(0, 5) == 0)
				n = $urandom_range(1, n - 1);
			if (n > RANDOM_ITEMS - random_items)
				n = RANDOM_ITEMS - random_items;
			set_frame_size(CFG_W'(w), CFG_W'(h));
			send_frame(n, 1'b0);
			drain();
			random_items += n;
		end

		@(negedge clk);
		if (error_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

FILE: heightmap_central_difference_slope.f
rtl/core/hcds_pkg.sv
rtl/core/hcds_fifo.sv
rtl/core/hcds_front.sv
rtl/core/hcds_back.sv
rtl/core/heightmap_central_difference_slope.sv
tb/slope_checker.sv
tb/tb.sv
